// ===== rtl/ytu_pkg.sv =====
package ytu_pkg;

  localparam int YAW_W     = 13;
  localparam int TILT_IN_W = 13;
  localparam int ACC_IN_W  = 15;
  localparam int CAL_W     = 2;
  localparam int TILT_W    = 14;
  localparam int ACC_W     = 16;
  localparam int TOT_W     = 32;
  localparam int DEG_W     = 9;

  localparam int DEG_FULL    = 360;
  localparam int DEG_HALF    = 180;
  localparam int ACCEL_LIMIT = 31360;

  // Pipeline stage numbers, from the input register to the output register.
  localparam int STG_IN   = 1;
  localparam int STG_QUOT = 2;
  localparam int STG_REM  = 3;
  localparam int STG_QUAD = 4;
  localparam int STG_ROM  = 5;
  localparam int STG_PROD = 6;
  localparam int STG_SUM  = 7;
  localparam int STG_RND  = 8;
  localparam int STG_OUT  = 9;
  localparam int NSTG     = 9;

  typedef logic [NSTG:1] stage_vec_t;

  typedef struct packed {
    logic [YAW_W-1:0]            yaw;
    logic signed [TILT_IN_W-1:0] pitch;
    logic signed [TILT_IN_W-1:0] roll;
    logic signed [ACC_IN_W-1:0]  ax;
    logic signed [ACC_IN_W-1:0]  ay;
    logic                        lock;
    logic signed [TOT_W-1:0]     total;
    logic                        total_valid;
  } item_t;

endpackage

// ===== rtl/ytu_angle_reduce.sv =====
module ytu_angle_reduce import ytu_pkg::*; #(
  parameter int ANGLE_LSB_PER_DEGREE = 16
) (
  input  logic             clk,
  input  stage_vec_t       en,
  input  logic [YAW_W-1:0] yaw,
  output logic [1:0]       quad,
  output logic [$clog2(90*ANGLE_LSB_PER_DEGREE+1)-1:0] rem,
  output logic [DEG_W-1:0] deg
);

  localparam int AW            = $clog2(90*ANGLE_LSB_PER_DEGREE+1);
  localparam int QUARTER_UNITS = 90*ANGLE_LSB_PER_DEGREE;
  localparam int FULL_UNITS    = 360*ANGLE_LSB_PER_DEGREE;
  localparam int RECIP_SH      = 26;
  localparam logic [39:0] RECIP_FULL = 40'((longint'(1) << RECIP_SH) / FULL_UNITS);
  localparam logic [39:0] RECIP_DEG  = 40'((longint'(1) << RECIP_SH) / ANGLE_LSB_PER_DEGREE);
  localparam logic [15:0] FULL_W = 16'(FULL_UNITS);
  localparam logic [15:0] LSB_W  = 16'(ANGLE_LSB_PER_DEGREE);
  localparam logic [15:0] Q1_W   = 16'(QUARTER_UNITS);
  localparam logic [15:0] Q2_W   = 16'(2*QUARTER_UNITS);
  localparam logic [15:0] Q3_W   = 16'(3*QUARTER_UNITS);

  logic [39:0]      prod_f, prod_d;
  logic [YAW_W-1:0] yaw2, quo_f2, quo_d2;
  logic [28:0]      mul_f, mul_d;
  logic [YAW_W-1:0] rem_f3, rem_d3, quo_d3;
  logic [15:0]      ang, off;
  logic [1:0]       quad_next;
  logic [YAW_W-1:0] deg_wide;

  assign prod_f = 40'(yaw) * RECIP_FULL;
  assign prod_d = 40'(yaw) * RECIP_DEG;

  always_ff @(posedge clk) begin
    if (en[STG_QUOT]) begin
      yaw2   <= yaw;
      quo_f2 <= prod_f[RECIP_SH +: YAW_W];
      quo_d2 <= prod_d[RECIP_SH +: YAW_W];
    end
  end

  assign mul_f = 29'(quo_f2) * 29'(FULL_UNITS);
  assign mul_d = 29'(quo_d2) * 29'(ANGLE_LSB_PER_DEGREE);

  always_ff @(posedge clk) begin
    if (en[STG_REM]) begin
      rem_f3 <= YAW_W'(29'(yaw2) - mul_f);
      rem_d3 <= YAW_W'(29'(yaw2) - mul_d);
      quo_d3 <= quo_d2;
    end
  end

  always_comb begin
    ang = (16'(rem_f3) >= FULL_W) ? 16'(rem_f3) - FULL_W : 16'(rem_f3);
    if (ang >= Q3_W) begin
      quad_next = 2'd3;
      off       = Q3_W;
    end else if (ang >= Q2_W) begin
      quad_next = 2'd2;
      off       = Q2_W;
    end else if (ang >= Q1_W) begin
      quad_next = 2'd1;
      off       = Q1_W;
    end else begin
      quad_next = 2'd0;
      off       = '0;
    end
    deg_wide = (16'(rem_d3) >= LSB_W) ? quo_d3 + YAW_W'(1) : quo_d3;
  end

  always_ff @(posedge clk) begin
    if (en[STG_QUAD]) begin
      quad <= quad_next;
      rem  <= AW'(ang - off);
      deg  <= deg_wide[DEG_W-1:0];
    end
  end

endmodule

// ===== rtl/ytu_sine_rom.sv =====
module ytu_sine_rom import ytu_pkg::*; #(
  parameter int ANGLE_LSB_PER_DEGREE = 16,
  parameter int SINE_FRAC_BITS       = 15
) (
  input  logic       clk,
  input  stage_vec_t en,
  input  logic [1:0] quad,
  input  logic [$clog2(90*ANGLE_LSB_PER_DEGREE+1)-1:0] rem,
  output logic [SINE_FRAC_BITS:0] s_mag,
  output logic [SINE_FRAC_BITS:0] c_mag,
  output logic       s_neg,
  output logic       c_neg
);

  localparam int AW            = $clog2(90*ANGLE_LSB_PER_DEGREE+1);
  localparam int TW            = SINE_FRAC_BITS + 1;
  localparam int QUARTER_UNITS = 90*ANGLE_LSB_PER_DEGREE;
  localparam int DEPTH         = QUARTER_UNITS + 1;
  localparam longint HALF_PI_Q30 = 64'd1686629713;
  localparam longint TAYLOR_DIV [12] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420, 506, 600};
  localparam logic [AW-1:0] QUARTER_A = AW'(QUARTER_UNITS);

  typedef logic [TW-1:0] rom_t [DEPTH];

  // Quarter-wave sine in Q30 by a Taylor series, rounded to the table format.
  function automatic logic [TW-1:0] quarter_sine(input longint k);
    longint x;
    longint x2;
    longint term;
    longint sum;
    x    = (k * HALF_PI_Q30 + longint'(QUARTER_UNITS / 2)) / QUARTER_UNITS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int n = 1; n <= 12; n++) begin
      term = (term * x2) >> 30;
      term = term / TAYLOR_DIV[n-1];
      if ((n % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + (longint'(1) << (29 - SINE_FRAC_BITS))) >> (30 - SINE_FRAC_BITS);
    return sum[TW-1:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < DEPTH; k++) begin
      r[k] = quarter_sine(longint'(k));
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [AW-1:0] s_addr, c_addr;

  assign s_addr = quad[0] ? QUARTER_A - rem : rem;
  assign c_addr = quad[0] ? rem : QUARTER_A - rem;

  always_ff @(posedge clk) begin
    if (en[STG_ROM]) begin
      s_mag <= SINE_ROM[s_addr];
      c_mag <= SINE_ROM[c_addr];
      s_neg <= quad[1];
      c_neg <= quad[1] ^ quad[0];
    end
  end

endmodule

// ===== rtl/ytu_unwrap.sv =====
module ytu_unwrap import ytu_pkg::*; #(
  parameter int ANGLE_LSB_PER_DEGREE = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    upd,
  input  logic [YAW_W-1:0]        yaw,
  input  logic [DEG_W-1:0]        deg,
  output logic signed [TOT_W-1:0] yaw_total
);

  localparam int PLW = $clog2((2**DEG_W - 1)*ANGLE_LSB_PER_DEGREE + 1);
  localparam int BW  = ((PLW > YAW_W) ? PLW : YAW_W) + 2;
  localparam logic [PLW-1:0]       DEG_SCALE = PLW'(ANGLE_LSB_PER_DEGREE);
  localparam logic signed [BW-1:0] HALF_L    = BW'(DEG_HALF*ANGLE_LSB_PER_DEGREE);
  localparam logic signed [BW-1:0] FULL_L    = BW'(DEG_FULL*ANGLE_LSB_PER_DEGREE);
  localparam logic [DEG_W-1:0]     D_FULL    = DEG_W'(DEG_FULL);
  localparam logic [DEG_W-1:0]     D_HALF    = DEG_W'(DEG_HALF);
  localparam logic signed [TOT_W-1:0] TOT_MAX = {1'b0, {(TOT_W-1){1'b1}}};
  localparam logic signed [TOT_W-1:0] TOT_MIN = {1'b1, {(TOT_W-1){1'b0}}};

  logic [DEG_W-1:0]          prev;
  logic [PLW-1:0]            prev_l;
  logic signed [DEG_W:0]     diff;
  logic [DEG_W-1:0]          adiff, dmod, delta;
  logic signed [BW-1:0]      big;
  logic                      plus;
  logic signed [TOT_W:0]     step, sum;
  logic signed [TOT_W-1:0]   total_next;

  always_comb begin
    diff  = $signed({1'b0, deg}) - $signed({1'b0, prev});
    adiff = diff[DEG_W] ? DEG_W'(-diff) : DEG_W'(diff);
    dmod  = (adiff >= D_FULL) ? adiff - D_FULL : adiff;
    delta = (dmod > D_HALF) ? D_FULL - dmod : dmod;
    big   = $signed(BW'(yaw)) - $signed(BW'(prev_l));
    plus  = (big >= 0 && big <= HALF_L) || (big <= -HALF_L && big >= -FULL_L);
    step  = plus ? $signed((TOT_W+1)'(delta)) : -$signed((TOT_W+1)'(delta));
    sum   = $signed({yaw_total[TOT_W-1], yaw_total}) + step;
    if (sum[TOT_W] != sum[TOT_W-1]) begin
      total_next = sum[TOT_W] ? TOT_MIN : TOT_MAX;
    end else begin
      total_next = sum[TOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev      <= '0;
      prev_l    <= '0;
      yaw_total <= '0;
    end else if (upd) begin
      prev      <= deg;
      prev_l    <= PLW'(deg) * DEG_SCALE;
      yaw_total <= total_next;
    end
  end

  a_prev_follows: assert property (@(posedge clk) disable iff (rst)
    upd |=> prev == $past(deg))
    else $error("previous heading not taken from the unwrapped beat");

  a_total_holds: assert property (@(posedge clk) disable iff (rst)
    !upd |=> $stable(yaw_total))
    else $error("heading total changed without a locked beat");

endmodule

// ===== rtl/ytu_rotate.sv =====
module ytu_rotate import ytu_pkg::*; #(
  parameter int ANGLE_LSB_PER_DEGREE = 16,
  parameter int SINE_FRAC_BITS       = 15
) (
  input  logic                        clk,
  input  stage_vec_t                  en,
  input  logic [SINE_FRAC_BITS:0]     s_mag,
  input  logic [SINE_FRAC_BITS:0]     c_mag,
  input  logic                        s_neg,
  input  logic                        c_neg,
  input  logic signed [TILT_IN_W-1:0] pitch,
  input  logic signed [TILT_IN_W-1:0] roll,
  input  logic signed [ACC_IN_W-1:0]  ax,
  input  logic signed [ACC_IN_W-1:0]  ay,
  output logic signed [TILT_W-1:0]    ns_tilt,
  output logic signed [TILT_W-1:0]    ew_tilt,
  output logic signed [ACC_W-1:0]     ns_acc,
  output logic signed [ACC_W-1:0]     ew_acc
);

  localparam int PW = SINE_FRAC_BITS + 17;
  localparam int SW = PW + 1;
  localparam int RW = SW - SINE_FRAC_BITS;
  localparam logic [SW-1:0] HALF = SW'(1) << (SINE_FRAC_BITS - 1);
  localparam logic [RW-1:0] TILT_LIM = RW'(DEG_FULL*ANGLE_LSB_PER_DEGREE);
  localparam logic [RW-1:0] ACC_LIM  = RW'(ACCEL_LIMIT);

  logic signed [PW-1:0] sm, cm, p_w, r_w, ax_w, ay_w;
  logic signed [PW-1:0] cp6, sr6, sp6, cr6, cax6, say6, sax6, cay6;
  logic                 sn6, cn6;
  logic signed [SW-1:0] sum7 [4];
  logic [SW-1:0]        mag [4];
  logic [SW-1:0]        rnd [4];
  logic [RW-1:0]        rm8 [4];
  logic                 neg8 [4];
  logic [RW-1:0]        lim [4];
  logic signed [RW:0]   val [4];

  assign sm   = PW'($signed({1'b0, s_mag}));
  assign cm   = PW'($signed({1'b0, c_mag}));
  assign p_w  = PW'(pitch);
  assign r_w  = PW'(roll);
  assign ax_w = PW'(ax);
  assign ay_w = PW'(ay);

  always_ff @(posedge clk) begin
    if (en[STG_PROD]) begin
      cp6  <= cm * p_w;
      sr6  <= sm * r_w;
      sp6  <= sm * p_w;
      cr6  <= cm * r_w;
      cax6 <= cm * ax_w;
      say6 <= sm * ay_w;
      sax6 <= sm * ax_w;
      cay6 <= cm * ay_w;
      sn6  <= s_neg;
      cn6  <= c_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (en[STG_SUM]) begin
      sum7[0] <= (cn6 ? SW'(cp6) : -SW'(cp6)) + (sn6 ? -SW'(sr6) : SW'(sr6));
      sum7[1] <= (sn6 ? SW'(sp6) : -SW'(sp6)) + (cn6 ? SW'(cr6) : -SW'(cr6));
      sum7[2] <= (cn6 ? SW'(cax6) : -SW'(cax6)) + (sn6 ? -SW'(say6) : SW'(say6));
      sum7[3] <= (sn6 ? SW'(sax6) : -SW'(sax6)) + (cn6 ? SW'(cay6) : -SW'(cay6));
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i] = sum7[i][SW-1] ? SW'(-sum7[i]) : SW'(sum7[i]);
      rnd[i] = mag[i] + HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (en[STG_RND]) begin
      for (int i = 0; i < 4; i++) begin
        rm8[i]  <= rnd[i][SW-1:SINE_FRAC_BITS];
        neg8[i] <= sum7[i][SW-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (i < 2) begin
        lim[i] = (rm8[i] > TILT_LIM) ? TILT_LIM : rm8[i];
      end else begin
        lim[i] = (rm8[i] > ACC_LIM) ? ACC_LIM : rm8[i];
      end
      val[i] = neg8[i] ? -$signed({1'b0, lim[i]}) : $signed({1'b0, lim[i]});
    end
  end

  assign ns_tilt = val[0][TILT_W-1:0];
  assign ew_tilt = val[1][TILT_W-1:0];
  assign ns_acc  = val[2][ACC_W-1:0];
  assign ew_acc  = val[3][ACC_W-1:0];

endmodule

// ===== rtl/yaw_referenced_tilt_and_heading_unwrap_core.sv =====
// Yaw-referenced tilt and acceleration with heading unwrap.
// Input channel: one orientation sample per beat (yaw, pitch, roll, linear
// acceleration x and y, system calibration level), taken when in_valid is high
// and in_stall is low. Output channel: one result beat per input beat, in order,
// delivered when out_valid is high and out_stall is low.
// The block is a nine-stage pipeline: the input register, yaw reduction by
// reciprocal multiply, remainder, quadrant, a quarter-wave sine ROM with two
// registered read ports, the eight rotation products, their four sums,
// rounding, and the output register.
// Throughput is one beat per cycle while the receiver does not stall; the
// heading total is a saturating accumulator at the ROM stage.
// The lock flag sets on the first beat with a nonzero calibration level and
// stays set until reset. Before lock the beat passes through unrotated and the
// heading total reads zero with total_yaw_valid low.
// Reset clears the lock flag, the heading state and all stage valid bits.
// While the receiver stalls, the result is held and bubbles in the pipeline
// are squeezed out; in_stall rises only once every stage holds a beat.
module yaw_referenced_tilt_and_heading_unwrap_core import ytu_pkg::*; #(
  parameter int ANGLE_LSB_PER_DEGREE = 16,
  parameter int SINE_FRAC_BITS       = 15
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [YAW_W-1:0]            yaw_sixteenths,
  input  logic signed [TILT_IN_W-1:0] pitch_sixteenths,
  input  logic signed [TILT_IN_W-1:0] roll_sixteenths,
  input  logic signed [ACC_IN_W-1:0]  accel_x_centi,
  input  logic signed [ACC_IN_W-1:0]  accel_y_centi,
  input  logic [CAL_W-1:0]            sys_calibration,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [TILT_W-1:0]    ns_tilt,
  output logic signed [TILT_W-1:0]    ew_tilt,
  output logic signed [ACC_W-1:0]     ns_acc,
  output logic signed [ACC_W-1:0]     ew_acc,
  output logic signed [TOT_W-1:0]     total_yaw,
  output logic                        total_yaw_valid
);

  localparam int AW = $clog2(90*ANGLE_LSB_PER_DEGREE+1);
  localparam int TW = SINE_FRAC_BITS + 1;

  stage_vec_t v, vin, rdy, en;
  logic       locked, lock_item;
  item_t      pipe    [STG_IN:STG_RND];
  item_t      side_in [STG_IN:STG_RND];

  logic [1:0]              quad;
  logic [AW-1:0]           rem;
  logic [DEG_W-1:0]        deg;
  logic [TW-1:0]           s_mag, c_mag;
  logic                    s_neg, c_neg;
  logic signed [TOT_W-1:0] yaw_total;
  logic signed [TILT_W-1:0] rot_ns_tilt, rot_ew_tilt;
  logic signed [ACC_W-1:0]  rot_ns_acc, rot_ew_acc;

  always_comb begin
    vin = {v[NSTG-1:1], in_valid};
    rdy[NSTG] = !v[NSTG] || !out_stall;
    for (int k = NSTG - 1; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
    en = vin & rdy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (rdy & vin) | (~rdy & v);
    end
  end

  assign in_stall  = !rdy[STG_IN];
  assign out_valid = v[STG_OUT];

  assign lock_item = locked || (sys_calibration != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      locked <= 1'b0;
    end else if (en[STG_IN]) begin
      locked <= lock_item;
    end
  end

  always_comb begin
    side_in[STG_IN].yaw         = yaw_sixteenths;
    side_in[STG_IN].pitch       = pitch_sixteenths;
    side_in[STG_IN].roll        = roll_sixteenths;
    side_in[STG_IN].ax          = accel_x_centi;
    side_in[STG_IN].ay          = accel_y_centi;
    side_in[STG_IN].lock        = lock_item;
    side_in[STG_IN].total       = '0;
    side_in[STG_IN].total_valid = 1'b0;
    for (int k = STG_QUOT; k <= STG_RND; k++) begin
      side_in[k] = pipe[k-1];
    end
    side_in[STG_PROD].total       = pipe[STG_ROM].lock ? yaw_total : '0;
    side_in[STG_PROD].total_valid = pipe[STG_ROM].lock;
  end

  always_ff @(posedge clk) begin
    for (int k = STG_IN; k <= STG_RND; k++) begin
      if (en[k]) begin
        pipe[k] <= side_in[k];
      end
    end
  end

  ytu_angle_reduce #(
    .ANGLE_LSB_PER_DEGREE(ANGLE_LSB_PER_DEGREE)
  ) u_reduce (
    .clk  (clk),
    .en   (en),
    .yaw  (pipe[STG_IN].yaw),
    .quad (quad),
    .rem  (rem),
    .deg  (deg)
  );

  ytu_sine_rom #(
    .ANGLE_LSB_PER_DEGREE(ANGLE_LSB_PER_DEGREE),
    .SINE_FRAC_BITS      (SINE_FRAC_BITS)
  ) u_rom (
    .clk   (clk),
    .en    (en),
    .quad  (quad),
    .rem   (rem),
    .s_mag (s_mag),
    .c_mag (c_mag),
    .s_neg (s_neg),
    .c_neg (c_neg)
  );

  ytu_unwrap #(
    .ANGLE_LSB_PER_DEGREE(ANGLE_LSB_PER_DEGREE)
  ) u_unwrap (
    .clk       (clk),
    .rst       (rst),
    .upd       (en[STG_ROM] && pipe[STG_QUAD].lock),
    .yaw       (pipe[STG_QUAD].yaw),
    .deg       (deg),
    .yaw_total (yaw_total)
  );

  ytu_rotate #(
    .ANGLE_LSB_PER_DEGREE(ANGLE_LSB_PER_DEGREE),
    .SINE_FRAC_BITS      (SINE_FRAC_BITS)
  ) u_rotate (
    .clk     (clk),
    .en      (en),
    .s_mag   (s_mag),
    .c_mag   (c_mag),
    .s_neg   (s_neg),
    .c_neg   (c_neg),
    .pitch   (pipe[STG_ROM].pitch),
    .roll    (pipe[STG_ROM].roll),
    .ax      (pipe[STG_ROM].ax),
    .ay      (pipe[STG_ROM].ay),
    .ns_tilt (rot_ns_tilt),
    .ew_tilt (rot_ew_tilt),
    .ns_acc  (rot_ns_acc),
    .ew_acc  (rot_ew_acc)
  );

  always_ff @(posedge clk) begin
    if (en[STG_OUT]) begin
      ns_tilt         <= pipe[STG_RND].lock ? rot_ns_tilt : TILT_W'(pipe[STG_RND].pitch);
      ew_tilt         <= pipe[STG_RND].lock ? rot_ew_tilt : TILT_W'(pipe[STG_RND].roll);
      ns_acc          <= pipe[STG_RND].lock ? rot_ns_acc  : ACC_W'(pipe[STG_RND].ay);
      ew_acc          <= pipe[STG_RND].lock ? rot_ew_acc  : ACC_W'(pipe[STG_RND].ax);
      total_yaw       <= pipe[STG_RND].total;
      total_yaw_valid <= pipe[STG_RND].total_valid;
    end
  end

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while the output register is empty");

  a_lock_sticky: assert property (@(posedge clk) disable iff (rst)
    locked |=> locked)
    else $error("lock flag cleared without reset");

  a_total_zero_unlocked: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !total_yaw_valid) |-> total_yaw == '0)
    else $error("heading total nonzero on an unlocked beat");

endmodule

// ===== bench/yaw_referenced_tilt_and_heading_unwrap_core_test.sv =====
module yaw_referenced_tilt_and_heading_unwrap_core_test;
  import ytu_pkg::*;

  localparam int LSB          = 16;
  localparam int FRAC         = 15;
  localparam int QUARTER      = 90 * LSB;
  localparam int FULL         = DEG_FULL * LSB;
  localparam int TILT_LIMIT   = DEG_FULL * LSB;
  localparam int RANDOM_BEATS = 400;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN        = 20;

  typedef struct packed {
    logic [YAW_W-1:0]            yaw;
    logic signed [TILT_IN_W-1:0] pitch;
    logic signed [TILT_IN_W-1:0] roll;
    logic signed [ACC_IN_W-1:0]  ax;
    logic signed [ACC_IN_W-1:0]  ay;
    logic [CAL_W-1:0]            cal;
  } sample_t;

  typedef struct packed {
    logic signed [TILT_W-1:0] ns_tilt;
    logic signed [TILT_W-1:0] ew_tilt;
    logic signed [ACC_W-1:0]  ns_acc;
    logic signed [ACC_W-1:0]  ew_acc;
    logic signed [TOT_W-1:0]  total;
    logic                     total_valid;
  } heading_result_t;

  typedef struct packed {
    sample_t         smp;
    logic            typed;
    heading_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [YAW_W-1:0] yaw_sixteenths = '0;
  logic signed [TILT_IN_W-1:0] pitch_sixteenths = '0;
  logic signed [TILT_IN_W-1:0] roll_sixteenths = '0;
  logic signed [ACC_IN_W-1:0] accel_x_centi = '0;
  logic signed [ACC_IN_W-1:0] accel_y_centi = '0;
  logic [CAL_W-1:0] sys_calibration = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [TILT_W-1:0] ns_tilt;
  logic signed [TILT_W-1:0] ew_tilt;
  logic signed [ACC_W-1:0] ns_acc;
  logic signed [ACC_W-1:0] ew_acc;
  logic signed [TOT_W-1:0] total_yaw;
  logic total_yaw_valid;

  longint quarter_wave [0:QUARTER];
  bit heading_locked = 1'b0;
  longint last_heading_deg = 0;
  int heading_total = 0;

  stim_row_t directed_rows[$];
  heading_result_t pending_results[$];
  heading_result_t oldest;

  int errors = 0;
  int results_seen = 0;
  int beats_sent = 0;
  int input_held = 0;
  int cycle_count = 0;
  int send_idle_pct = 16;
  int recv_stall_pct = 57;
  int hold_left = 0;
  bit hold_done = 1'b0;

  yaw_referenced_tilt_and_heading_unwrap_core uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .yaw_sixteenths(yaw_sixteenths),
    .pitch_sixteenths(pitch_sixteenths),
    .roll_sixteenths(roll_sixteenths),
    .accel_x_centi(accel_x_centi),
    .accel_y_centi(accel_y_centi),
    .sys_calibration(sys_calibration),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .ns_tilt(ns_tilt),
    .ew_tilt(ew_tilt),
    .ns_acc(ns_acc),
    .ew_acc(ew_acc),
    .total_yaw(total_yaw),
    .total_yaw_valid(total_yaw_valid)
  );

  always #5 clk = ~clk;

  function automatic longint sine_of(int a);
    int q;
    int r;
    q = (a / QUARTER) & 3;
    r = a % QUARTER;
    case (q)
      0: return quarter_wave[r];
      1: return quarter_wave[QUARTER - r];
      2: return -quarter_wave[r];
      default: return -quarter_wave[QUARTER - r];
    endcase
  endfunction

  function automatic longint round_sat(longint v, longint limit);
    longint mag;
    longint r;
    mag = (v < 0) ? -v : v;
    r = (mag + (longint'(1) << (FRAC - 1))) >>> FRAC;
    if (v < 0) r = -r;
    if (r > limit) r = limit;
    if (r < -limit) r = -limit;
    return r;
  endfunction

  function automatic heading_result_t rotate_and_unwrap(sample_t s);
    heading_result_t r;
    int a;
    longint sn, cs, p, ro, ax, ay;
    longint deg, diff, d, delta, big, t;
    bit plus;
    p = s.pitch;
    ro = s.roll;
    ax = s.ax;
    ay = s.ay;
    if (s.cal != 0) heading_locked = 1'b1;
    if (heading_locked) begin
      a = int'(s.yaw) % FULL;
      sn = sine_of(a);
      cs = sine_of((a + QUARTER) % FULL);
      r.ns_tilt = TILT_W'(round_sat(-cs * p + sn * ro, TILT_LIMIT));
      r.ew_tilt = TILT_W'(round_sat(-sn * p - cs * ro, TILT_LIMIT));
      r.ns_acc = ACC_W'(round_sat(-cs * ax + sn * ay, ACCEL_LIMIT));
      r.ew_acc = ACC_W'(round_sat(-sn * ax - cs * ay, ACCEL_LIMIT));
      deg = (longint'(s.yaw) / LSB) & 511;
      diff = deg - last_heading_deg;
      d = ((diff < 0) ? -diff : diff) % DEG_FULL;
      delta = (d > DEG_HALF) ? DEG_FULL - d : d;
      big = longint'(s.yaw) - last_heading_deg * LSB;
      plus = (big >= 0 && big <= DEG_HALF * LSB) ||
             (big <= -DEG_HALF * LSB && big >= -DEG_FULL * LSB);
      t = longint'(heading_total) + (plus ? delta : -delta);
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      heading_total = int'(t);
      last_heading_deg = deg;
      r.total = heading_total;
      r.total_valid = 1'b1;
    end else begin
      r.ns_tilt = TILT_W'(s.pitch);
      r.ew_tilt = TILT_W'(s.roll);
      r.ns_acc = ACC_W'(s.ay);
      r.ew_acc = ACC_W'(s.ax);
      r.total = '0;
      r.total_valid = 1'b0;
    end
    return r;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic add_row(int yaw, int pitch, int roll, int ax, int ay, int cal, bit typed,
                         int ns_t, int ew_t, int ns_a, int ew_a, int tot, int tv);
    stim_row_t r;
    r.smp.yaw = YAW_W'(yaw);
    r.smp.pitch = TILT_IN_W'(pitch);
    r.smp.roll = TILT_IN_W'(roll);
    r.smp.ax = ACC_IN_W'(ax);
    r.smp.ay = ACC_IN_W'(ay);
    r.smp.cal = CAL_W'(cal);
    r.typed = typed;
    r.want.ns_tilt = TILT_W'(ns_t);
    r.want.ew_tilt = TILT_W'(ew_t);
    r.want.ns_acc = ACC_W'(ns_a);
    r.want.ew_acc = ACC_W'(ew_a);
    r.want.total = tot;
    r.want.total_valid = 1'(tv);
    directed_rows.push_back(r);
  endtask

  task automatic send_beat(sample_t s, bit typed, heading_result_t typed_want);
    heading_result_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    yaw_sixteenths <= s.yaw;
    pitch_sixteenths <= s.pitch;
    roll_sixteenths <= s.roll;
    accel_x_centi <= s.ax;
    accel_y_centi <= s.ay;
    sys_calibration <= s.cal;
    do @(posedge clk); while (in_stall);
    predicted = rotate_and_unwrap(s);
    pending_results.push_back(typed ? typed_want : predicted);
    beats_sent++;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (in_valid && in_stall) input_held++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      out_stall <= 1'b1;
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with none expected, actual ns_tilt %0d total_yaw %0d",
                 $time, ns_tilt, total_yaw);
        errors++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("ns_tilt", longint'(oldest.ns_tilt), longint'(ns_tilt));
        check_field("ew_tilt", longint'(oldest.ew_tilt), longint'(ew_tilt));
        check_field("ns_acc", longint'(oldest.ns_acc), longint'(ns_acc));
        check_field("ew_acc", longint'(oldest.ew_acc), longint'(ew_acc));
        check_field("total_yaw", longint'(oldest.total), longint'(total_yaw));
        check_field("total_yaw_valid", longint'(oldest.total_valid),
                    longint'(total_yaw_valid));
      end
    end
  end

  initial begin
    sample_t s;
    heading_result_t none;
    longint x, x2, term, acc;
    int yaw_walk;
    int pick;

    for (int k = 0; k <= QUARTER; k++) begin
      x = (longint'(k) * 64'd1686629713 + QUARTER / 2) / QUARTER;
      x2 = (x * x) >>> 30;
      term = x;
      acc = x;
      for (int n = 1; n <= 12; n++) begin
        term = (term * x2) >>> 30;
        term = term / ((2 * n) * (2 * n + 1));
        if (n % 2 == 1) acc = acc - term;
        else acc = acc + term;
      end
      if (acc < 0) acc = 0;
      quarter_wave[k] = (acc + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
    end

    // Before lock the sample passes straight through; the first calibrated sample
    // at zero heading negates tilt and acceleration exactly.
    add_row(   0,     0,     0,      0,      0, 0, 1,     0,     0,      0,      0, 0, 0);
    add_row(8191, -4096,  4095, -16384,  16383, 0, 1, -4096,  4095,  16383, -16384, 0, 0);
    add_row(5759,  2880, -2880,  15680, -15680, 0, 1,  2880, -2880, -15680,  15680, 0, 0);
    add_row(4096,  4095, -4096,  16383, -16384, 0, 1,  4095, -4096, -16384,  16383, 0, 0);
    add_row(   0,   100,  -200,   1000,  -2000, 1, 1,  -100,   200,  -1000,   2000, 0, 1);
    add_row(1440,  2880, -2880,  15680, -15680, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(2880,  -123,   456,   -789,   1011, 2, 0, 0, 0, 0, 0, 0, 0);
    add_row(   0,  2880,  2880,  15680,  15680, 3, 0, 0, 0, 0, 0, 0, 0);
    add_row(5744, -2880, -2880, -15680, -15680, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(  16,     1,    -1,      1,     -1, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(4320,   777,  -555,   3333,  -4444, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row( 720, -4096,  4095, -16384,  16383, 2, 0, 0, 0, 0, 0, 0, 0);
    add_row( 720,  4095, -4096,  16383, -16384, 3, 0, 0, 0, 0, 0, 0, 0);
    add_row(2160, -4096, -4096, -16384, -16384, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(5760,  1000,  2000,   3000,   4000, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(8191, -4096, -4096, -16384, -16384, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(6000,  4095,  4095,  16383,  16383, 2, 0, 0, 0, 0, 0, 0, 0);
    add_row(5759, -4096,  4095, -16384, -16384, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(   3,    17,   -17,     99,    -99, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(2888,  -500,   500,  -5000,   5000, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(   1,  2047, -2048,   8191,  -8192, 3, 0, 0, 0, 0, 0, 0, 0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].want);
    end

    // Mostly a slow random walk of the heading so the unwrap sees small steps and
    // wraps through north, with some arbitrary and out-of-range jumps mixed in.
    none = '0;
    yaw_walk = 16;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == RANDOM_BEATS / 3) begin
        send_idle_pct = 57;
        recv_stall_pct = 16;
      end else if (i == 2 * RANDOM_BEATS / 3) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        yaw_walk = (yaw_walk + int'($urandom_range(400)) - 200 + FULL) % FULL;
        s.yaw = YAW_W'(yaw_walk);
      end else if (pick < 90) begin
        yaw_walk = $urandom_range(FULL - 1);
        s.yaw = YAW_W'(yaw_walk);
      end else begin
        s.yaw = YAW_W'($urandom);
        yaw_walk = int'(s.yaw) % FULL;
      end
      if ($urandom_range(99) < 80) begin
        s.pitch = TILT_IN_W'(int'($urandom_range(5760)) - 2880);
        s.roll = TILT_IN_W'(int'($urandom_range(5760)) - 2880);
        s.ax = ACC_IN_W'(int'($urandom_range(31360)) - 15680);
        s.ay = ACC_IN_W'(int'($urandom_range(31360)) - 15680);
      end else begin
        s.pitch = TILT_IN_W'($urandom);
        s.roll = TILT_IN_W'($urandom);
        s.ax = ACC_IN_W'($urandom);
        s.ay = ACC_IN_W'($urandom);
      end
      s.cal = CAL_W'($urandom);
      send_beat(s, 1'b0, none);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Checked %0d result beats from %0d samples (%0d directed), lock and unwrap.",
             results_seen, beats_sent, directed_rows.size());
    $display("Input held off for %0d cycles under back-pressure; heading total %0d degrees.",
             input_held, heading_total);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
